// ===== hdl/actr_pkg.sv =====
// Shared types, constants and AES helper functions for the counter-mode cipher.
// No dependencies.
package actr_pkg;

   localparam int unsigned BlockBits = 128;
   localparam int unsigned CountBits = 5;
   localparam int unsigned ByteTotal = 16;
   localparam int unsigned RoundLast = 10;

   typedef enum logic [1:0] {
      CSR_KEY_HI   = 2'd0,
      CSR_KEY_LO   = 2'd1,
      CSR_CHECK_HI = 2'd2,
      CSR_CHECK_LO = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_HEADER = 1'b0,
      KIND_DATA   = 1'b1
   } kind_type;

   typedef struct packed {
      logic                 header;
      logic [BlockBits-1:0] data;
      logic [BlockBits-1:0] ctr_block;
      logic [CountBits-1:0] count;
   } job_type;

   typedef logic [7:0] byte_type;

   function automatic byte_type sbox(input byte_type x);
      byte_type r;
      case (x)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r=8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type rcon(input logic [3:0] rnd);
      byte_type r;
      case (rnd)
         4'd1: r=8'h01; 4'd2: r=8'h02; 4'd3: r=8'h04; 4'd4: r=8'h08;
         4'd5: r=8'h10; 4'd6: r=8'h20; 4'd7: r=8'h40; 4'd8: r=8'h80;
         4'd9: r=8'h1b; 4'd10: r=8'h36;
         default: r=8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type dbl(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits [127-8i -: 8]
   function automatic byte_type get_byte(input logic [BlockBits-1:0] b, input int i);
      return b[BlockBits-1-8*i -: 8];
   endfunction

   function automatic logic [BlockBits-1:0] next_round_key(
      input logic [BlockBits-1:0] k, input logic [3:0] rnd);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [BlockBits-1:0] aes_round(
      input logic [BlockBits-1:0] s, input logic [BlockBits-1:0] k, input logic last);
      logic [BlockBits-1:0] t, m;
      byte_type a0, a1, a2, a3, all;
      for (int col = 0; col < 4; col++) begin
         for (int i = 0; i < 4; i++) begin
            t[BlockBits-1-8*(i+4*col) -: 8] = sbox(get_byte(s, i + 4*((col+i)%4)));
         end
      end
      m = t;
      if (!last) begin
         for (int col = 0; col < 4; col++) begin
            a0 = get_byte(t, 4*col);   a1 = get_byte(t, 4*col+1);
            a2 = get_byte(t, 4*col+2); a3 = get_byte(t, 4*col+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            m[BlockBits-1-8*(4*col)   -: 8] = a0 ^ all ^ dbl(a0 ^ a1);
            m[BlockBits-1-8*(4*col+1) -: 8] = a1 ^ all ^ dbl(a1 ^ a2);
            m[BlockBits-1-8*(4*col+2) -: 8] = a2 ^ all ^ dbl(a2 ^ a3);
            m[BlockBits-1-8*(4*col+3) -: 8] = a3 ^ all ^ dbl(a3 ^ a0);
         end
      end
      return m ^ k;
   endfunction

endpackage

// ===== hdl/actr_stream_if.sv =====
// Valid/ready stream interface with a generic payload type.
// Depends on nothing.
interface actr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/actr_front.sv =====
// Front end: accepts requests, keeps the block counter, forms counter blocks.
// Depends on actr_pkg.
module actr_front import actr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_kind,
   input  logic [BlockBits-1:0] in_data,
   input  logic [CountBits-1:0] in_count,
   input  logic [BlockBits-1:0] key,
   output logic                 job_valid,
   input  logic                 job_ready,
   output job_type              job
);
   logic [63:0]          counter_ff, counter_in;
   logic [CountBits-1:0] count_sat;
   logic                 drop;

   assign in_ready = job_ready;
   assign drop     = (in_kind == KIND_DATA) && (in_count == '0);
   assign count_sat = (in_count > CountBits'(ByteTotal)) ? CountBits'(ByteTotal) : in_count;
   assign counter_in = (in_kind == KIND_HEADER) ? 64'd1 : counter_ff + 64'd1;
   assign job_valid  = in_valid && !drop;

   always_comb begin
      job.header = (in_kind == KIND_HEADER);
      job.data   = in_data;
      job.count  = (in_kind == KIND_HEADER) ? CountBits'(ByteTotal) : count_sat;
      for (int i = 0; i < 16; i++) begin
         job.ctr_block[BlockBits-1-8*i -: 8] = get_byte(key, i) ^ counter_in[8*(i%8) +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (in_valid && in_ready && !drop) begin
         counter_ff <= counter_in;
      end
   end
endmodule

// ===== hdl/actr_queue.sv =====
// Two-entry queue between front end and cipher core.
// Depends on actr_pkg.
module actr_queue import actr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  job_type wr_job,
   output logic    rd_valid,
   input  logic    rd_ready,
   output job_type rd_job
);
   job_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   assign wr_ready = (fill_ff != 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign rd_job   = mem_ff[rptr_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'd2) else $error("queue fill out of range");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd2) |-> !wr_ready) else $error("full queue accepts");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0) |-> !pop) else $error("pop from empty queue");
endmodule

// ===== hdl/actr_core.sv =====
// Cipher core: one AES round per cycle with on-the-fly key schedule, result register.
// Depends on actr_pkg.
module actr_core import actr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  job_type              job,
   input  logic [BlockBits-1:0] key,
   input  logic [BlockBits-1:0] check,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [BlockBits-1:0] out_data,
   output logic [CountBits-1:0] out_count,
   output logic                 out_check_ok
);
   logic                 busy_ff;
   logic [3:0]           round_ff;
   logic [BlockBits-1:0] state_ff, rkey_ff, nkey, nstate, mask, res;
   logic                 header_ff;
   logic [BlockBits-1:0] data_ff;
   logic [CountBits-1:0] count_ff;
   logic                 done, start;
   logic                 ovalid_ff;
   logic [BlockBits-1:0] odata_ff;
   logic [CountBits-1:0] ocount_ff;
   logic                 ook_ff;

   assign nkey   = next_round_key(rkey_ff, round_ff);
   assign nstate = aes_round(state_ff, nkey, round_ff == 4'(RoundLast));
   assign done   = busy_ff && (round_ff == 4'(RoundLast));
   assign job_ready = !busy_ff || (done && (!ovalid_ff || out_ready));
   assign start  = job_valid && job_ready;
   assign mask   = nstate;

   always_comb begin
      res = '0;
      if (header_ff) begin
         res = mask ^ check;
      end else begin
         for (int i = 0; i < 16; i++) begin
            if (CountBits'(i) < count_ff) begin
               res[BlockBits-1-8*i -: 8] = get_byte(mask, i) ^ get_byte(data_ff, i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         state_ff  <= job.ctr_block ^ key;
         rkey_ff   <= key;
         header_ff <= job.header;
         data_ff   <= job.data;
         count_ff  <= job.count;
      end else if (busy_ff && !done) begin
         state_ff <= nstate;
         rkey_ff  <= nkey;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= 4'd1;
      end else if (start) begin
         busy_ff  <= 1'b1;
         round_ff <= 4'd1;
      end else if (busy_ff && !done) begin
         round_ff <= round_ff + 4'd1;
      end else if (done && (!ovalid_ff || out_ready)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (done && (!ovalid_ff || out_ready)) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done && (!ovalid_ff || out_ready)) begin
         odata_ff  <= res;
         ocount_ff <= count_ff;
         ook_ff    <= header_ff && (res == data_ff);
      end
   end

   assign out_valid    = ovalid_ff;
   assign out_data     = odata_ff;
   assign out_count    = ocount_ff;
   assign out_check_ok = ook_ff;

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (round_ff >= 4'd1 && round_ff <= 4'(RoundLast)))
      else $error("round counter out of range");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (!busy_ff || done)) else $error("job taken mid-cipher");
   a_round_adv: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !done && !start) |=> (round_ff == $past(round_ff) + 4'd1))
      else $error("round counter stalled");
endmodule

// ===== hdl/aes128_ctr_stream_cipher.sv =====
// Top level of the AES-128 counter-mode stream cipher.
// Depends on actr_pkg, actr_stream_if, actr_front, actr_queue, actr_core.
//
// Requests carry kind, a 16-byte block and a byte count; responses carry the
// masked block, the count and the header check flag. Both channels use
// valid/ready; an item moves when both are high.
// Write key_hi, key_lo, check_hi, check_lo through csr_ while idle.
// A header request restarts the counter at one and returns mask XOR check.
// A data request with zero byte count returns nothing and leaves the counter.
// The front end counts and builds the counter block in the accept cycle and
// pushes it into a two-entry queue. The core folds the first key addition
// into its load and runs one AES round per cycle; the last round feeds the
// output register, and the core takes the next block only as it finishes
// the current one.
// The result sits in an output register, so the core starts the next block
// while the receiver stalls; the queue then fills and req_ready drops.
// Reset clears the counter, the key and check registers, the queue and all valid flags.
module aes128_ctr_stream_cipher import actr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [63:0]              req_data_hi,
   input  logic [63:0]              req_data_lo,
   input  logic [CountBits-1:0]     req_byte_count,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [63:0]              rsp_out_hi,
   output logic [63:0]              rsp_out_lo,
   output logic [CountBits-1:0]     rsp_out_count,
   output logic                     rsp_check_ok,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [63:0]              csr_data
);
   logic [63:0] key_hi_ff, key_lo_ff, check_hi_ff, check_lo_ff;
   logic [BlockBits-1:0] rsp_data;

   actr_stream_if #(.payload_type(job_type)) fq ();
   actr_stream_if #(.payload_type(job_type)) qc ();

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff   <= '0;
         key_lo_ff   <= '0;
         check_hi_ff <= '0;
         check_lo_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_HI:   key_hi_ff   <= csr_data;
            CSR_KEY_LO:   key_lo_ff   <= csr_data;
            CSR_CHECK_HI: check_hi_ff <= csr_data;
            CSR_CHECK_LO: check_lo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   actr_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_kind(req_kind),
      .in_data({req_data_hi, req_data_lo}), .in_count(req_byte_count),
      .key({key_hi_ff, key_lo_ff}),
      .job_valid(fq.valid), .job_ready(fq.ready), .job(fq.payload)
   );

   actr_queue u_queue (
      .clock, .reset,
      .wr_valid(fq.valid), .wr_ready(fq.ready), .wr_job(fq.payload),
      .rd_valid(qc.valid), .rd_ready(qc.ready), .rd_job(qc.payload)
   );

   actr_core u_core (
      .clock, .reset,
      .job_valid(qc.valid), .job_ready(qc.ready), .job(qc.payload),
      .key({key_hi_ff, key_lo_ff}), .check({check_hi_ff, check_lo_ff}),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data),
      .out_count(rsp_out_count), .out_check_ok(rsp_check_ok)
   );

   assign rsp_out_hi = rsp_data[127:64];
   assign rsp_out_lo = rsp_data[63:0];
endmodule
